@@ rtl/eucd_pkg.sv @@
// ----------------------------------------------------------------------------
// eucd_pkg
// Shared widths, controller states and the command/status bundles that join
// the euclidean distance controller and datapath.
// ----------------------------------------------------------------------------
package eucd_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int SQ_W      = 2 * SAMPLE_W;
  localparam int SUM_W     = 46;
  localparam int DIST_W    = SUM_W / 2;
  localparam int REM_W     = DIST_W + 2;
  localparam int STEP_W    = $clog2(DIST_W);
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [STEP_W-1:0] LastStep = STEP_W'(DIST_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_ROOT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;        // capture an input pair
    logic mul;         // register the squared difference
    logic acc;         // add the square into the running sum
    logic root_start;  // move the sum into the root unit, clear the sum
    logic root_step;   // one root bit
    logic out_load;    // present the result
  } cmd_t;

  typedef struct packed {
    logic last;        // captured pair closes the vector
    logic root_last;   // root unit is on its final bit
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

@@ rtl/eucd_ctrl.sv @@
// ----------------------------------------------------------------------------
// eucd_ctrl
// Sequencer for one element pair at a time: capture, square, accumulate, and
// on the last pair run the bit-serial square root and hand off the result.
// ----------------------------------------------------------------------------
module eucd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  eucd_pkg::status_t sts,
  output eucd_pkg::cmd_t    cmd
);
  import eucd_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (sts.last) begin
          state_next = ST_ROOT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ROOT: begin
        // one root bit per cycle, the sum was handed over in the accumulate cycle
        cmd.root_step = 1'b1;
        if (sts.root_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // sum is handed to the root unit as the accumulate of the last pair lands
    cmd.root_start = (state == ST_ACC) && sts.last;
  end

`ifndef SYNTHESIS
  a_no_input_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_tready)
    else $error("input taken while a pair is in flight");

  a_short_pair_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACC && !sts.last) |=> (state == ST_IDLE))
    else $error("non-final pair did not return to idle");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_one_datapath_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.mul, cmd.root_step, cmd.out_load}))
    else $error("conflicting datapath commands");
`endif

endmodule

@@ rtl/eucd_dp.sv @@
// ----------------------------------------------------------------------------
// eucd_dp
// Datapath: pair capture, absolute difference and square, saturating 46-bit
// accumulator, restoring square root one bit per cycle, output register.
// ----------------------------------------------------------------------------
module eucd_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [eucd_pkg::SAMPLE_W-1:0]     elem_a,
  input  logic [eucd_pkg::SAMPLE_W-1:0]     elem_b,
  input  logic                              last_elem,
  input  eucd_pkg::cmd_t                    cmd,
  output eucd_pkg::status_t                 sts,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [eucd_pkg::DIST_W-1:0]       distance,
  output logic                              sum_saturated
);
  import eucd_pkg::*;

  logic [SAMPLE_W-1:0] a_reg;
  logic [SAMPLE_W-1:0] b_reg;
  logic                last_reg;
  logic [SQ_W-1:0]     sq_reg;
  logic [SUM_W-1:0]    sum;
  logic                sat;
  logic [SUM_W-1:0]    rad;
  logic [REM_W-1:0]    rem;
  logic [DIST_W-1:0]   root;
  logic                root_sat;
  logic [STEP_W-1:0]   step;

  logic [DIFF_W-1:0]   diff;
  logic [SAMPLE_W-1:0] mag;
  logic [SUM_W:0]      sum_wide;
  logic [REM_W+1:0]    rem_shift;
  logic [REM_W+1:0]    trial;
  logic [REM_W+1:0]    rem_sub;
  logic                fits;

  always_comb begin
    diff      = {a_reg[SAMPLE_W-1], a_reg} - {b_reg[SAMPLE_W-1], b_reg};
    mag       = diff[DIFF_W-1] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
    sum_wide  = {1'b0, sum} + (SUM_W+1)'(sq_reg);
    rem_shift = {rem, rad[SUM_W-1 -: 2]};
    trial     = (REM_W+2)'({root, 2'b01});
    rem_sub   = rem_shift - trial;
    fits      = rem_shift >= trial;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_reg    <= elem_a;
      b_reg    <= elem_b;
      last_reg <= last_elem;
    end
    if (cmd.mul) begin
      sq_reg <= SQ_W'(mag) * SQ_W'(mag);
    end
    // sum of the last pair goes straight to the root unit
    if (cmd.root_start) begin
      rad      <= sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      root_sat <= sat | sum_wide[SUM_W];
      rem      <= '0;
      root     <= '0;
    end else if (cmd.root_step) begin
      rad  <= {rad[SUM_W-3:0], 2'b00};
      rem  <= fits ? rem_sub[REM_W-1:0] : rem_shift[REM_W-1:0];
      root <= {root[DIST_W-2:0], fits};
    end
    if (cmd.out_load) begin
      distance      <= root;
      sum_saturated <= root_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      sat      <= 1'b0;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.root_start) begin
        sum <= '0;
        sat <= 1'b0;
      end else if (cmd.acc) begin
        if (sum_wide[SUM_W]) begin
          sum <= {SUM_W{1'b1}};
          sat <= 1'b1;
        end else begin
          sum <= sum_wide[SUM_W-1:0];
        end
      end
      if (cmd.root_start) begin
        step <= '0;
      end else if (cmd.root_step) begin
        step <= step + 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.last      = last_reg;
    sts.root_last = (step == LastStep);
    sts.out_free  = !m_tvalid || m_tready;
  end

endmodule

@@ rtl/euclidean_distance.sv @@
// ----------------------------------------------------------------------------
// euclidean_distance
// Streams two signed 16-bit fixed-point vectors one element pair per
// transfer, accumulates the squared differences into a 46-bit saturating sum
// and, on the pair marked with tlast, returns the floor square root of that
// sum in the input scale; tuser flags a saturated sum. Each pair passes
// through capture, 16x16 square and accumulate before the next is accepted.
// The final pair then runs the one-bit-per-cycle square root and loads the
// output register once it is free; the result then waits in the output
// register while the next vector streams in, holding back only the next
// result's load into the output register.
// ----------------------------------------------------------------------------
module euclidean_distance (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [eucd_pkg::IN_DATA_W-1:0]   s_tdata,   // elem_a [15:0], elem_b [31:16]
  input  logic                             s_tlast,   // last_elem
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [eucd_pkg::OUT_DATA_W-1:0]  m_tdata,   // distance [22:0], zero [23]
  output logic [0:0]                       m_tuser    // sum_saturated [0]
);
  import eucd_pkg::*;

  cmd_t              cmd;
  status_t           sts;
  logic [DIST_W-1:0] distance;
  logic              sum_saturated;

  eucd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  eucd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .elem_a        (s_tdata[SAMPLE_W-1:0]),
    .elem_b        (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .last_elem     (s_tlast),
    .cmd           (cmd),
    .sts           (sts),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .distance      (distance),
    .sum_saturated (sum_saturated)
  );

  assign m_tdata = OUT_DATA_W'(distance);
  assign m_tuser = sum_saturated;

endmodule
